FILE: rtl/srdbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scale-root delta bit packer: shared definitions
// Widths, command and register codes, the job record passed from the front
// end to the coder, and the bit length function.
// ----------------------------------------------------------------------------
package srdbp_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int NUM_W       = 32;
  localparam int ROOT_W      = 5;
  localparam int CMD_W       = 2;
  localparam int IDX_W       = 2;
  localparam int NLEN_W      = 6;
  localparam int LEN_W       = 7;
  localparam int CODE_W      = 64;
  localparam int BUF_W       = 72;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_DOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COUNT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOC   = 2'd2;

  localparam logic [IDX_W-1:0] REG_DOC_ROOT   = 2'd0;
  localparam logic [IDX_W-1:0] REG_COUNT_ROOT = 2'd1;
  localparam logic [IDX_W-1:0] REG_LOC_ROOT   = 2'd2;

  localparam logic [ROOT_W-1:0] DOC_ROOT_RST   = 5'd1;
  localparam logic [ROOT_W-1:0] COUNT_ROOT_RST = 5'd1;
  localparam logic [ROOT_W-1:0] LOC_ROOT_RST   = 5'd4;

  typedef struct packed {
    logic [VALUE_BITS-1:0] number;
    logic [ROOT_W-1:0]     root;
    logic                  has_code;
    logic                  end_doc;
  } job_t;

  typedef struct packed {
    logic idle;
    logic popping;
  } back_stat_t;

  // Number of significant bits, found by halving the search window.
  function automatic logic [NLEN_W-1:0] bit_length(input logic [NUM_W-1:0] x);
    logic [NUM_W-1:0] v;
    logic [4:0]       pos;
    begin
      v   = x;
      pos = '0;
      if (v[31:16] != '0) begin
        pos[4] = 1'b1;
        v      = v >> 16;
      end
      if (v[15:8] != '0) begin
        pos[3] = 1'b1;
        v      = v >> 8;
      end
      if (v[7:4] != '0) begin
        pos[2] = 1'b1;
        v      = v >> 4;
      end
      if (v[3:2] != '0) begin
        pos[1] = 1'b1;
        v      = v >> 2;
      end
      if (v[1]) begin
        pos[0] = 1'b1;
      end
      bit_length = (x == '0) ? '0 : ({1'b0, pos} + 6'd1);
    end
  endfunction

  function automatic logic [CODE_W-1:0] low_mask(input logic [LEN_W-1:0] k);
    begin
      low_mask = (64'd1 << k) - 64'd1;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/srdbp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Job queue
// Short first-in first-out buffer between the front end and the coder.
// ----------------------------------------------------------------------------
module srdbp_queue
  import srdbp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      push_job_i,
  input  wire logic pop_i,
  output job_t      head_job_o,
  output logic      full_o,
  output logic      empty_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign head_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/srdbp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Holds the root registers, takes input beats, forms the deltas and turns
// each beat into a job for the coder.
// ----------------------------------------------------------------------------
module srdbp_front
  import srdbp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [IDX_W-1:0]  cfg_index_i,
  input  wire logic [ROOT_W-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CMD_W-1:0]  command_i,
  input  wire logic [NUM_W-1:0]  value_i,
  input  wire logic              first_of_word_i,
  input  wire logic              end_of_document_i,
  input  wire logic              queue_full_i,
  output logic                   push_o,
  output job_t                   push_job_o
);

  logic [ROOT_W-1:0]     doc_root_q, count_root_q, loc_root_q;
  logic [VALUE_BITS-1:0] prev_doc_q, prev_doc_d;
  logic [VALUE_BITS-1:0] prev_loc_q, prev_loc_d;
  logic [VALUE_BITS-1:0] val, base;
  logic                  accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;
  assign val        = value_i[VALUE_BITS-1:0];

  always_comb begin
    prev_doc_d          = prev_doc_q;
    prev_loc_d          = prev_loc_q;
    base                = first_of_word_i ? '0 : prev_doc_q;
    push_job_o.end_doc  = end_of_document_i;
    push_job_o.has_code = 1'b1;
    push_job_o.number   = val;
    push_job_o.root     = count_root_q;
    case (command_i)
      CMD_DOC: begin
        push_job_o.number = val - base;
        push_job_o.root   = doc_root_q;
        prev_doc_d        = val;
        prev_loc_d        = '0;
      end
      CMD_COUNT: begin
        push_job_o.number = val;
        push_job_o.root   = count_root_q;
      end
      CMD_LOC: begin
        push_job_o.number = val - prev_loc_q;
        push_job_o.root   = loc_root_q;
        prev_loc_d        = val;
      end
      default: begin
        // Unused command: no code, but a flush still happens.
        push_job_o.has_code = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      doc_root_q   <= DOC_ROOT_RST;
      count_root_q <= COUNT_ROOT_RST;
      loc_root_q   <= LOC_ROOT_RST;
      prev_doc_q   <= '0;
      prev_loc_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_DOC_ROOT:   doc_root_q   <= cfg_data_i;
          REG_COUNT_ROOT: count_root_q <= cfg_data_i;
          REG_LOC_ROOT:   loc_root_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        prev_doc_q <= prev_doc_d;
        prev_loc_q <= prev_loc_d;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/srdbp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Coder and byte packer
// Takes one job at a time, builds its code word, merges it behind the
// pending bits and hands out the completed bytes one beat at a time.
// ----------------------------------------------------------------------------
module srdbp_back
  import srdbp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  job_t      head_job_i,
  input  wire logic queue_empty_i,
  output logic      pop_o,
  output back_stat_t stat_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic [7:0] out_byte_o,
  output logic      last_of_run_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CODE  = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [NUM_W-1:0]  num_q;
  logic [ROOT_W-1:0] root_q;
  logic              has_q, eod_q;
  logic [NLEN_W-1:0] nlen_q;
  logic [CODE_W-1:0] code_q, code_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [BUF_W-1:0]  buf_q, buf_d;
  logic [LEN_W-1:0]  tot_q, tot_d;
  logic [7:0]        pend_q, pend_d;
  logic [2:0]        pcnt_q, pcnt_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              last_q, last_d;

  logic [NLEN_W-1:0] prefix, rootbits, root_ext;
  logic [CODE_W-1:0] pre_mask, root_mask;
  logic [LEN_W-1:0]  rem, merge_tot, shamt;
  logic              slot_free;
  logic [NUM_W-1:0]  job_num;

  assign slot_free     = !out_valid_q || out_ready_i;
  assign pop_o         = (state_q == ST_IDLE) && !queue_empty_i;
  assign stat_o.idle    = (state_q == ST_IDLE);
  assign stat_o.popping = pop_o;
  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = last_q;
  assign job_num       = NUM_W'(head_job_i.number);

  // Code word, right aligned: ones prefix, a zero, then the root bits.
  always_comb begin
    root_ext  = {1'b0, root_q};
    prefix    = (nlen_q > root_ext) ? (nlen_q - root_ext) : '0;
    rootbits  = ((nlen_q != '0) && ((nlen_q - 6'd1) > root_ext)) ? (nlen_q - 6'd1) : root_ext;
    pre_mask  = low_mask({1'b0, prefix});
    root_mask = low_mask({1'b0, rootbits});
    if (has_q) begin
      code_d = (pre_mask << ({1'b0, rootbits} + 7'd1))
             | {{(CODE_W-NUM_W){1'b0}}, num_q & root_mask[NUM_W-1:0]};
      len_d  = {1'b0, prefix} + {1'b0, rootbits} + 7'd1;
    end else begin
      code_d = '0;
      len_d  = '0;
    end
  end

  always_comb begin
    merge_tot = {4'b0, pcnt_q} + len_q;
    shamt     = 7'(BUF_W) - merge_tot;
    rem       = tot_q - 7'd8;
    state_d     = state_q;
    buf_d       = buf_q;
    tot_d       = tot_q;
    pend_d      = pend_q;
    pcnt_d      = pcnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    case (state_q)
      ST_IDLE: begin
        if (!queue_empty_i) begin
          state_d = ST_CODE;
        end
      end
      ST_CODE: begin
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        // The code's first bit lands right behind the pending bits.
        buf_d   = {pend_q, {CODE_W{1'b0}}} | ({8'b0, code_q} << shamt);
        tot_d   = merge_tot;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (tot_q >= 7'd8) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_byte_d  = buf_q[BUF_W-1 -: 8];
            last_d      = (rem < 7'd8) && !(eod_q && (rem != '0));
            buf_d       = buf_q << 8;
            tot_d       = rem;
          end
        end else if (eod_q && (tot_q != '0)) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_byte_d  = buf_q[BUF_W-1 -: 8];
            last_d      = 1'b1;
            pend_d      = '0;
            pcnt_d      = '0;
            state_d     = ST_IDLE;
          end
        end else begin
          pend_d  = buf_q[BUF_W-1 -: 8];
          pcnt_d  = tot_q[2:0];
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      num_q  <= job_num;
      root_q <= head_job_i.root;
      has_q  <= head_job_i.has_code;
      eod_q  <= head_job_i.end_doc;
      nlen_q <= bit_length(job_num);
    end
    if (state_q == ST_CODE) begin
      code_q <= code_d;
      len_q  <= len_d;
    end
    buf_q      <= buf_d;
    tot_q      <= tot_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= '0;
      pcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      pcnt_q      <= pcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/scale_root_delta_bit_packer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scale-root delta bit packer
// Input beats carry a command (document index, entry count or location code),
// a 32-bit value and two flags. Document indices and location codes are
// turned into deltas, each value is coded in scale-2 root-r form and the code
// bits are packed MSB first into bytes on the output channel. A partial byte
// is padded with zeros and sent when end_of_document is set. last_of_run
// marks the final byte that a beat causes; a beat may cause no byte at all.
// Both channels use valid/ready. The root registers are written through the
// plain write port; the user must write them only while the block is idle,
// and the block itself does not enforce this. An accepted beat is written
// into the job queue; the coder, when idle, takes it from the queue, builds
// its code word, merges it behind the pending bits, hands out each completed
// byte through the output register and, unless a flush sends it, parks the
// partial byte before it goes back to idle. The coder sets the rate; a
// two-entry job queue lets the input side keep taking beats while it works.
// When the receiver stalls, the output register holds its byte and the
// coder, then the queue and finally in_ready_o back up.
// Reset clears the pending bits and the previous index and location, and sets
// the roots to 1, 1 and 4.
// ----------------------------------------------------------------------------
module scale_root_delta_bit_packer_top
  import srdbp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [IDX_W-1:0]  cfg_index_i,
  input  wire logic [ROOT_W-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CMD_W-1:0]  command_i,
  input  wire logic [NUM_W-1:0]  value_i,
  input  wire logic              first_of_word_i,
  input  wire logic              end_of_document_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   last_of_run_o
);

  logic       push, pop, q_full, q_empty;
  job_t       push_job, head_job;
  back_stat_t back_stat;

  srdbp_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .value_i           (value_i),
    .first_of_word_i   (first_of_word_i),
    .end_of_document_i (end_of_document_i),
    .queue_full_i      (q_full),
    .push_o            (push),
    .push_job_o        (push_job)
  );

  srdbp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_job_o (head_job),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  srdbp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_job_i    (head_job),
    .queue_empty_i (q_empty),
    .pop_o         (pop),
    .stat_o        (back_stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  a_queue_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty))
    else $error("job queue reports full and empty together");

  a_pop_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.popping |-> !q_empty)
    else $error("coder took a job from an empty queue");

  a_coder_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_stat.idle && !q_empty) |=> !back_stat.idle)
    else $error("coder stayed idle with a job waiting");

  a_byte_from_coder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!back_stat.idle))
    else $error("output beat appeared while the coder was idle");

endmodule
`default_nettype wire

FILE: test/scale_root_delta_bit_packer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scale-root delta bit packer testbench
// Drives document index, entry count and location code beats through the
// packer under random source gaps and sink stalls, across several root
// settings (zero, the maximum and the reset values among them). Every byte
// leaving the block is checked against a bit-level packing predictor kept
// in this file, or against values typed into the directed table where the
// result is obvious from reset state.
// ----------------------------------------------------------------------------
module scale_root_delta_bit_packer_top_tb;
  import srdbp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_CYCLES     = 300;
  localparam int HOLD_AFTER      = 100;
  localparam int WATCHDOG_LIMIT  = 5000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [NUM_W-1:0] value;
    logic             first;
    logic             eod;
    logic             known;
    logic [3:0]       known_n;
    logic [63:0]      known_bytes;
  } beat_row_t;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [IDX_W-1:0]  cfg_index  = '0;
  logic [ROOT_W-1:0] cfg_data   = '0;
  logic              in_valid   = 1'b0;
  logic [CMD_W-1:0]  command    = '0;
  logic [NUM_W-1:0]  value      = '0;
  logic              first      = 1'b0;
  logic              eod        = 1'b0;
  logic              out_ready  = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [7:0]        out_byte_o;
  logic              last_of_run_o;

  // Typed expectation travelling alongside the payload of the current beat.
  logic              beat_known   = 1'b0;
  logic [3:0]        beat_known_n = '0;
  logic [63:0]       beat_known_bytes = '0;

  // Predictor state.
  logic [ROOT_W-1:0] doc_root   = DOC_ROOT_RST;
  logic [ROOT_W-1:0] count_root = COUNT_ROOT_RST;
  logic [ROOT_W-1:0] loc_root   = LOC_ROOT_RST;
  logic [7:0]        pend_bits  = '0;
  int                pend_cnt   = 0;
  logic [NUM_W-1:0]  prev_doc   = '0;
  logic [NUM_W-1:0]  prev_loc   = '0;
  logic [7:0]        fresh_bytes[$];
  packed_byte_t      packed_byte_q[$];

  beat_row_t         dir_rows[$];
  int                errors      = 0;
  int                beats_in    = 0;
  int                bytes_out   = 0;
  int                idle_cycles = 0;
  bit                calm        = 1'b0;

  scale_root_delta_bit_packer_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .command_i         (command),
    .value_i           (value),
    .first_of_word_i   (first),
    .end_of_document_i (eod),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .out_byte_o        (out_byte_o),
    .last_of_run_o     (last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic push_code_bit(input logic b);
    pend_bits[7 - pend_cnt] = b;
    pend_cnt++;
    if (pend_cnt == 8) begin
      fresh_bytes.push_back(pend_bits);
      pend_bits = '0;
      pend_cnt  = 0;
    end
  endtask

  task automatic code_number(input logic [NUM_W-1:0] num, input logic [ROOT_W-1:0] root);
    int len;
    int prefix;
    int tail;
    int i;
    len = 0;
    for (i = 0; i < NUM_W; i++) begin
      if (num[i]) len = i + 1;
    end
    prefix = (len > int'(root)) ? len - int'(root) : 0;
    tail   = (len >= 1 && len - 1 > int'(root)) ? len - 1 : int'(root);
    repeat (prefix) push_code_bit(1'b1);
    push_code_bit(1'b0);
    for (i = tail; i > 0; i--) push_code_bit(num[i-1]);
  endtask

  // Codes one beat into fresh_bytes, updating the delta bases and partial byte.
  task automatic pack_item(input logic [CMD_W-1:0] cmd, input logic [NUM_W-1:0] val,
                           input logic first_flag, input logic eod_flag);
    logic [NUM_W-1:0] base;
    fresh_bytes.delete();
    case (cmd)
      CMD_DOC: begin
        base     = first_flag ? '0 : prev_doc;
        prev_doc = val;
        prev_loc = '0;
        code_number(val - base, doc_root);
      end
      CMD_COUNT: begin
        code_number(val, count_root);
      end
      CMD_LOC: begin
        base     = prev_loc;
        prev_loc = val;
        code_number(val - base, loc_root);
      end
      default: begin
      end
    endcase
    if (eod_flag && pend_cnt > 0) begin
      fresh_bytes.push_back(pend_bits);
      pend_bits = '0;
      pend_cnt  = 0;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    packed_byte_t want;
    int           k;
    if (rst_ni) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DOC_ROOT:   doc_root   = cfg_data;
          REG_COUNT_ROOT: count_root = cfg_data;
          REG_LOC_ROOT:   loc_root   = cfg_data;
          default: begin
          end
        endcase
      end
      if (out_valid_o && out_ready) begin
        bytes_out++;
        if (packed_byte_q.size() == 0) begin
          $display("%0t: byte %02h with nothing expected", $time, out_byte_o);
          errors++;
        end else begin
          want = packed_byte_q.pop_front();
          if (out_byte_o !== want.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte_o);
            errors++;
          end
          if (last_of_run_o !== want.last) begin
            $display("%0t: last_of_run expected %0b actual %0b", $time, want.last,
                     last_of_run_o);
            errors++;
          end
        end
      end
      if (in_valid && in_ready_o) begin
        beats_in++;
        pack_item(command, value, first, eod);
        if (beat_known) begin
          for (k = 0; k < int'(beat_known_n); k++) begin
            want.data = beat_known_bytes[63 - 8*k -: 8];
            want.last = (k == int'(beat_known_n) - 1);
            packed_byte_q.push_back(want);
          end
        end else begin
          for (k = 0; k < fresh_bytes.size(); k++) begin
            want.data = fresh_bytes[k];
            want.last = (k == fresh_bytes.size() - 1);
            packed_byte_q.push_back(want);
          end
        end
      end
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 75) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Sink side: random stalls, plus one long hold-off so the block backs up.
  initial begin : sink
    int  stall_left;
    int  hold_left;
    bit  held;
    stall_left = 0;
    hold_left  = 0;
    held       = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!held && beats_in >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic send_beat(input beat_row_t row);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid         <= 1'b1;
    command          <= row.cmd;
    value            <= row.value;
    first            <= row.first;
    eod              <= row.eod;
    beat_known       <= row.known;
    beat_known_n     <= row.known_n;
    beat_known_bytes <= row.known_bytes;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [NUM_W-1:0] val,
                         input logic first_flag, input logic eod_flag, input logic known,
                         input logic [3:0] n, input logic [63:0] bytes);
    beat_row_t row;
    row.cmd         = cmd;
    row.value       = val;
    row.first       = first_flag;
    row.eod         = eod_flag;
    row.known       = known;
    row.known_n     = n;
    row.known_bytes = bytes;
    dir_rows.push_back(row);
  endtask

  task automatic write_root(input logic [IDX_W-1:0] idx, input logic [ROOT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
  endtask

  // Waits for every expected byte, then lets a beat that makes no byte finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (packed_byte_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [NUM_W-1:0] pick_value(input logic [NUM_W-1:0] base);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return base + $urandom_range(0, 300);
    if (r < 75) return base + ($urandom >> $urandom_range(0, 31));
    if (r < 88) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return 32'h0000_0001;
    endcase
  endfunction

  initial begin : source
    beat_row_t        row;
    logic [NUM_W-1:0] gen_doc;
    logic [NUM_W-1:0] gen_loc;
    logic [NUM_W-1:0] base;
    int               r;
    gen_doc = '0;
    gen_loc = '0;

    // Rows with typed results start from reset state with every byte flushed.
    add_row(CMD_NONE,  32'h0000_0000, 1'b0, 1'b1, 1'b1, 4'd0, 64'h0);
    add_row(CMD_DOC,   32'h0000_0000, 1'b1, 1'b1, 1'b1, 4'd1, 64'h0000_0000_0000_0000);
    add_row(CMD_DOC,   32'h0000_0001, 1'b0, 1'b1, 1'b1, 4'd1, 64'h4000_0000_0000_0000);
    add_row(CMD_COUNT, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 4'd8, 64'hFFFF_FFFE_FFFF_FFFE);
    add_row(CMD_LOC,   32'h0000_0000, 1'b0, 1'b1, 1'b1, 4'd1, 64'h0000_0000_0000_0000);
    add_row(CMD_LOC,   32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 4'd8, 64'hFFFF_FFF7_FFFF_FFF0);
    add_row(CMD_LOC,   32'h0000_0000, 1'b0, 1'b1, 1'b1, 4'd1, 64'h0800_0000_0000_0000);
    // The word flag on a count is ignored; a new document resets the location base.
    add_row(CMD_COUNT, 32'h0000_0005, 1'b1, 1'b0, 1'b0, 4'd0, 64'h0);
    add_row(CMD_DOC,   32'h0000_0007, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
    add_row(CMD_LOC,   32'h0000_0003, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
    add_row(CMD_NONE,  32'h1234_5678, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
    add_row(CMD_NONE,  32'h0000_0000, 1'b0, 1'b1, 1'b0, 4'd0, 64'h0);
    add_row(CMD_NONE,  32'h0000_0000, 1'b0, 1'b1, 1'b1, 4'd0, 64'h0);
    add_row(CMD_DOC,   32'h8000_0000, 1'b1, 1'b0, 1'b0, 4'd0, 64'h0);
    add_row(CMD_DOC,   32'h0000_0000, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
    add_row(CMD_LOC,   32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
    add_row(CMD_LOC,   32'h0000_0001, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
    add_row(CMD_COUNT, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
    add_row(CMD_COUNT, 32'h0000_0001, 1'b0, 1'b1, 1'b0, 4'd0, 64'h0);
    add_row(CMD_DOC,   32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 4'd0, 64'h0);
    add_row(CMD_COUNT, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 4'd0, 64'h0);
    add_row(CMD_LOC,   32'hAAAA_AAAA, 1'b0, 1'b1, 1'b0, 4'd0, 64'h0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: begin
            write_root(REG_DOC_ROOT, 5'd0);
            write_root(REG_COUNT_ROOT, 5'd0);
            write_root(REG_LOC_ROOT, 5'd0);
          end
          2: begin
            write_root(REG_DOC_ROOT, 5'd31);
            write_root(REG_COUNT_ROOT, 5'd31);
            write_root(REG_LOC_ROOT, 5'd31);
          end
          3: begin
            write_root(REG_DOC_ROOT, 5'd0);
            write_root(REG_COUNT_ROOT, 5'd31);
            write_root(REG_LOC_ROOT, 5'd1);
          end
          4: begin
            write_root(REG_DOC_ROOT, 5'd7);
            write_root(REG_COUNT_ROOT, 5'd2);
            write_root(REG_LOC_ROOT, 5'd16);
          end
          default: begin
            write_root(REG_DOC_ROOT, 5'($urandom_range(0, 31)));
            write_root(REG_COUNT_ROOT, 5'($urandom_range(0, 31)));
            write_root(REG_LOC_ROOT, 5'($urandom_range(0, 31)));
          end
        endcase
        cfg_we <= 1'b0;
      end
      // One phase runs with no gaps on either side.
      calm = (phase == 2);
      if (phase == 0) begin
        foreach (dir_rows[i]) send_beat(dir_rows[i]);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r               = $urandom_range(0, 99);
        row.known       = 1'b0;
        row.known_n     = '0;
        row.known_bytes = '0;
        row.first       = ($urandom_range(0, 3) == 0);
        row.eod         = ($urandom_range(0, 4) == 0);
        if (r < 20)      row.cmd = CMD_DOC;
        else if (r < 35) row.cmd = CMD_COUNT;
        else if (r < 90) row.cmd = CMD_LOC;
        else             row.cmd = CMD_NONE;
        // Mostly ascending documents and locations, as a real index produces.
        case (row.cmd)
          CMD_DOC: base = row.first ? '0 : gen_doc;
          CMD_LOC: base = gen_loc;
          default: base = '0;
        endcase
        row.value = pick_value(base);
        if (row.cmd == CMD_DOC) begin
          gen_doc = row.value;
          gen_loc = '0;
        end else if (row.cmd == CMD_LOC) begin
          gen_loc = row.value;
        end
        send_beat(row);
      end
    end

    drain();
    $display("Covered %0d beats (%0d from the directed table) and %0d bytes over %0d root",
             beats_in, dir_rows.size(), bytes_out, NUM_PHASES);
    $display("settings, roots 0 to 31, with random stalls and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
